/* design/assert_macros.svh */
// Assertion macros shared by the window statistics modules.
// Each macro expects aclk and aresetn to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define A_IMPLY(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define A_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* design/wnds_pkg.sv */
// Shared constants, codes and control structs for the window statistics core.
// No dependencies; used by the controller, the datapath and the top level.
package wnds_pkg;

    localparam int DEF_WINDOW_SIZE = 6;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int DEF_COORD_BITS  = 14;

    localparam int FRAC_BITS  = 32;
    localparam int CV_BITS    = 32;
    localparam int ROOT_BITS  = 2 * (CV_BITS - 1);
    localparam int ROOT_STEPS = CV_BITS - 1;

    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;

    localparam logic [1:0] REG_CENTER_COL   = 2'd0;
    localparam logic [1:0] REG_CENTER_ROW   = 2'd1;
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd2;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd3;

    localparam logic [1:0] CV_ST_OK    = 2'd0;
    localparam logic [1:0] CV_ST_EMPTY = 2'd1;
    localparam logic [1:0] CV_ST_SAT   = 2'd2;

    localparam logic [CV_BITS-1:0] CV_MAX = {1'b0, {(CV_BITS-1){1'b1}}};
    localparam logic [CV_BITS-1:0] CV_MIN = {1'b1, {(CV_BITS-1){1'b0}}};

    typedef struct packed {
        logic load;
        logic win_clear;
        logic q_clear;
        logic rd_en;
        logic mul;
        logic sub;
        logic div_step;
        logic root_init;
        logic root_step;
        logic out_load;
    } wnds_cmd_t;

    typedef struct packed {
        logic last_item;
        logic count_zero;
        logic sum_zero;
    } wnds_stat_t;

endpackage

/* design/window_ndvi_statistics_core.sv */
// Window NDVI statistics: one sample word per cycle while loading (none while computing), then
// a squares pass over the n valid samples (at most 36), a one-bit-per-cycle
// divider (76 steps) and a 31-step square root.
// Words of the next window are taken while a finished result waits on m_ready.
// Synchronous active-low reset clears the window and restores the register defaults.
module window_ndvi_statistics_core #(
    parameter int WINDOW_SIZE = wnds_pkg::DEF_WINDOW_SIZE,
    parameter int SAMPLE_BITS = wnds_pkg::DEF_SAMPLE_BITS,
    parameter int COORD_BITS  = wnds_pkg::DEF_COORD_BITS
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         psel,
    input  logic                                         penable,
    input  logic                                         pwrite,
    input  logic [wnds_pkg::APB_ADDR_BITS-1:0]           paddr,
    input  logic [wnds_pkg::APB_DATA_BITS-1:0]           pwdata,
    output logic [wnds_pkg::APB_DATA_BITS-1:0]           prdata,
    output logic                                         pready,
    input  logic                                         s_valid,
    output logic                                         s_ready,
    input  logic signed [SAMPLE_BITS-1:0]                s_ndvi_sample,
    input  logic                                         s_sample_is_number,
    output logic                                         m_valid,
    input  logic                                         m_ready,
    output logic [$clog2(WINDOW_SIZE*WINDOW_SIZE+1)-1:0] m_negative_count,
    output logic signed [wnds_pkg::CV_BITS-1:0]          m_coeff_variation,
    output logic [1:0]                                   m_cv_status
);
    import wnds_pkg::*;

    localparam int ITEMS = WINDOW_SIZE * WINDOW_SIZE;
    localparam int AW    = $clog2(ITEMS);
    localparam int NW    = $clog2(ITEMS + 1);

    logic [COORD_BITS-1:0] center_col_reg, center_row_reg;
    logic [COORD_BITS:0]   image_width_reg, image_height_reg;
    logic                  wr_en;
    logic [1:0]            reg_idx;
    wnds_cmd_t             cmd;
    wnds_stat_t            stat;
    logic [NW-1:0]         valid_count;
    logic [AW-1:0]         rd_addr;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_col_reg   <= '0;
            center_row_reg   <= '0;
            image_width_reg  <= {1'b1, {COORD_BITS{1'b0}}};
            image_height_reg <= {1'b1, {COORD_BITS{1'b0}}};
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_CENTER_COL:   center_col_reg   <= pwdata[COORD_BITS-1:0];
                REG_CENTER_ROW:   center_row_reg   <= pwdata[COORD_BITS-1:0];
                REG_IMAGE_WIDTH:  image_width_reg  <= pwdata[COORD_BITS:0];
                REG_IMAGE_HEIGHT: image_height_reg <= pwdata[COORD_BITS:0];
                default:          ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_CENTER_COL:   prdata = APB_DATA_BITS'(center_col_reg);
            REG_CENTER_ROW:   prdata = APB_DATA_BITS'(center_row_reg);
            REG_IMAGE_WIDTH:  prdata = APB_DATA_BITS'(image_width_reg);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_BITS'(image_height_reg);
            default:          prdata = '0;
        endcase
    end

    wnds_ctrl #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .stat        (stat),
        .valid_count (valid_count),
        .cmd         (cmd),
        .rd_addr     (rd_addr)
    );

    wnds_dp #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COORD_BITS  (COORD_BITS)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .stat               (stat),
        .valid_count        (valid_count),
        .rd_addr            (rd_addr),
        .center_col         (center_col_reg),
        .center_row         (center_row_reg),
        .image_width        (image_width_reg),
        .image_height       (image_height_reg),
        .s_ndvi_sample      (s_ndvi_sample),
        .s_sample_is_number (s_sample_is_number),
        .m_negative_count   (m_negative_count),
        .m_coeff_variation  (m_coeff_variation),
        .m_cv_status        (m_cv_status)
    );

endmodule

/* design/wnds_ctrl.sv */
// Sequencing state machine of the window statistics core.
// Depends on wnds_pkg and assert_macros.svh; drives the datapath by command struct.
`include "assert_macros.svh"
module wnds_ctrl #(
    parameter int WINDOW_SIZE = wnds_pkg::DEF_WINDOW_SIZE,
    parameter int SAMPLE_BITS = wnds_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         s_valid,
    output logic                                         s_ready,
    output logic                                         m_valid,
    input  logic                                         m_ready,
    input  wnds_pkg::wnds_stat_t                         stat,
    input  logic [$clog2(WINDOW_SIZE*WINDOW_SIZE+1)-1:0] valid_count,
    output wnds_pkg::wnds_cmd_t                          cmd,
    output logic [$clog2(WINDOW_SIZE*WINDOW_SIZE)-1:0]   rd_addr
);
    import wnds_pkg::*;

    localparam int ITEMS = WINDOW_SIZE * WINDOW_SIZE;
    localparam int AW    = $clog2(ITEMS);
    localparam int NW    = $clog2(ITEMS + 1);
    localparam int DW    = 2 * SAMPLE_BITS + 2 * NW;
    localparam int DIVW  = DW + FRAC_BITS;
    localparam int CW    = $clog2(DIVW + 1);

    typedef enum logic [9:0] {
        S_LOAD  = 10'b00_0000_0001,
        S_CHECK = 10'b00_0000_0010,
        S_SQ    = 10'b00_0000_0100,
        S_TAIL  = 10'b00_0000_1000,
        S_MUL   = 10'b00_0001_0000,
        S_SUB   = 10'b00_0010_0000,
        S_DIV   = 10'b00_0100_0000,
        S_RINIT = 10'b00_1000_0000,
        S_ROOT  = 10'b01_0000_0000,
        S_DONE  = 10'b10_0000_0000
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_LOAD: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid && stat.last_item) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                cnt_next = '0;
                if (stat.count_zero || stat.sum_zero) begin
                    state_next = S_DONE;
                end else begin
                    cmd.q_clear = 1'b1;
                    state_next  = S_SQ;
                end
            end
            S_SQ: begin
                cmd.rd_en = 1'b1;
                if (cnt_reg == CW'(valid_count) - CW'(1)) begin
                    state_next = S_TAIL;
                end else begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            S_TAIL: begin
                state_next = S_MUL;
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_SUB;
            end
            S_SUB: begin
                cmd.sub    = 1'b1;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CW'(DIVW - 1)) begin
                    state_next = S_RINIT;
                end else begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            S_RINIT: begin
                cmd.root_init = 1'b1;
                cnt_next      = '0;
                state_next    = S_ROOT;
            end
            S_ROOT: begin
                cmd.root_step = 1'b1;
                if (cnt_reg == CW'(ROOT_STEPS - 1)) begin
                    state_next = S_DONE;
                end else begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load  = 1'b1;
                    cmd.win_clear = 1'b1;
                    state_next    = S_LOAD;
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_LOAD;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign rd_addr = cnt_reg[AW-1:0];

    // A new result must never overwrite one that has not been taken.
    `A_IMPLY(a_no_overwrite, cmd.out_load, !m_valid_reg || m_ready)
    `A_NEXT(a_last_to_check, s_valid && s_ready && stat.last_item, state_reg == S_CHECK)
    `A_IMPLY(a_read_in_range, cmd.rd_en, cnt_reg < CW'(valid_count))

endmodule

/* design/wnds_dp.sv */
// Datapath of the window statistics core: sample store, sums, divider and root.
// Depends on wnds_pkg and assert_macros.svh; commanded by wnds_ctrl.
`include "assert_macros.svh"
module wnds_dp #(
    parameter int WINDOW_SIZE = wnds_pkg::DEF_WINDOW_SIZE,
    parameter int SAMPLE_BITS = wnds_pkg::DEF_SAMPLE_BITS,
    parameter int COORD_BITS  = wnds_pkg::DEF_COORD_BITS
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  wnds_pkg::wnds_cmd_t                          cmd,
    output wnds_pkg::wnds_stat_t                         stat,
    output logic [$clog2(WINDOW_SIZE*WINDOW_SIZE+1)-1:0] valid_count,
    input  logic [$clog2(WINDOW_SIZE*WINDOW_SIZE)-1:0]   rd_addr,
    input  logic [COORD_BITS-1:0]                        center_col,
    input  logic [COORD_BITS-1:0]                        center_row,
    input  logic [COORD_BITS:0]                          image_width,
    input  logic [COORD_BITS:0]                          image_height,
    input  logic signed [SAMPLE_BITS-1:0]                s_ndvi_sample,
    input  logic                                         s_sample_is_number,
    output logic [$clog2(WINDOW_SIZE*WINDOW_SIZE+1)-1:0] m_negative_count,
    output logic signed [wnds_pkg::CV_BITS-1:0]          m_coeff_variation,
    output logic [1:0]                                   m_cv_status
);
    import wnds_pkg::*;

    localparam int ITEMS = WINDOW_SIZE * WINDOW_SIZE;
    localparam int AW    = $clog2(ITEMS);
    localparam int NW    = $clog2(ITEMS + 1);
    localparam int PW    = $clog2(WINDOW_SIZE);
    localparam int HALF  = WINDOW_SIZE / 2;
    localparam int CW    = COORD_BITS + 1;
    localparam int SUMW  = SAMPLE_BITS + NW;
    localparam int SQW   = 2 * SAMPLE_BITS;
    localparam int QW    = SQW + NW;
    localparam int DW    = QW + NW;
    localparam int DIVW  = DW + FRAC_BITS;
    localparam int QPW   = (DIVW > ROOT_BITS) ? DIVW : ROOT_BITS + 1;

    logic [NW-1:0]          count_reg;
    logic [NW-1:0]          tally_reg;
    logic signed [SUMW-1:0] sum_reg;
    logic [PW-1:0]          col_reg, row_reg;
    logic signed [SAMPLE_BITS-1:0] mem [ITEMS];
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;
    logic                   rd_valid_reg;
    logic [QW-1:0]          q_reg;
    logic [DW-1:0]          s2_reg, nq_reg, rem_reg;
    logic [DIVW-1:0]        dq_reg;
    logic [ROOT_BITS-1:0]   v_reg, r_reg, b_reg;

    logic [CW-1:0]          col_pos, row_pos;
    logic                   in_image, good;
    logic [SUMW-1:0]        smag;
    logic signed [SQW-1:0]  sq;
    logic [DW:0]            trial, diff;
    logic                   ge;
    logic [QPW-1:0]         qx;
    logic                   sat;
    logic [ROOT_BITS:0]     rb;
    logic [CV_BITS-1:0]     mag;

    // Window position of this word relative to the image.
    assign col_pos  = CW'(center_col) + CW'(col_reg);
    assign row_pos  = CW'(center_row) + CW'(row_reg);
    assign in_image = (col_pos >= CW'(HALF)) && ((col_pos - CW'(HALF)) < image_width) &&
                      (row_pos >= CW'(HALF)) && ((row_pos - CW'(HALF)) < image_height);
    assign good     = in_image && s_sample_is_number && (count_reg < NW'(ITEMS));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            tally_reg <= '0;
            sum_reg   <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
        end else if (cmd.win_clear) begin
            count_reg <= '0;
            tally_reg <= '0;
            sum_reg   <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
        end else if (cmd.load) begin
            if (good) begin
                count_reg <= count_reg + NW'(1);
                sum_reg   <= sum_reg + SUMW'(s_ndvi_sample);
                if (s_ndvi_sample[SAMPLE_BITS-1]) begin
                    tally_reg <= tally_reg + NW'(1);
                end
            end
            if (row_reg == PW'(WINDOW_SIZE - 1)) begin
                row_reg <= '0;
                col_reg <= col_reg + PW'(1);
            end else begin
                row_reg <= row_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load && good) begin
            mem[count_reg[AW-1:0]] <= s_ndvi_sample;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= cmd.rd_en;
        end
    end

    assign sq   = rd_data_reg * rd_data_reg;
    assign smag = sum_reg[SUMW-1] ? SUMW'(-sum_reg) : SUMW'(sum_reg);

    // Restoring division of D * 2^32 by S^2, one quotient bit per cycle.
    assign trial = {rem_reg, dq_reg[DIVW-1]};
    assign diff  = trial - {1'b0, s2_reg};
    assign ge    = trial >= {1'b0, s2_reg};
    assign qx    = QPW'(dq_reg);
    assign sat   = |qx[QPW-1:ROOT_BITS];
    assign rb    = {1'b0, r_reg} + {1'b0, b_reg};
    assign mag   = {1'b0, r_reg[CV_BITS-2:0]};

    always_ff @(posedge aclk) begin
        if (cmd.q_clear) begin
            q_reg <= '0;
        end else if (rd_valid_reg) begin
            q_reg <= q_reg + QW'(unsigned'(sq));
        end
        if (cmd.mul) begin
            s2_reg <= DW'(smag) * DW'(smag);
            nq_reg <= DW'(count_reg) * DW'(q_reg);
        end
        if (cmd.sub) begin
            rem_reg <= '0;
            dq_reg  <= {nq_reg - s2_reg, {FRAC_BITS{1'b0}}};
        end else if (cmd.div_step) begin
            rem_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
            dq_reg  <= {dq_reg[DIVW-2:0], ge};
        end
        // Digit-by-digit integer square root, two radicand bits per cycle.
        if (cmd.root_init) begin
            v_reg <= qx[ROOT_BITS-1:0];
            r_reg <= '0;
            b_reg <= ROOT_BITS'(1) << (2 * (ROOT_STEPS - 1));
        end else if (cmd.root_step) begin
            if ({1'b0, v_reg} >= rb) begin
                v_reg <= v_reg - rb[ROOT_BITS-1:0];
                r_reg <= (r_reg >> 1) + b_reg;
            end else begin
                r_reg <= r_reg >> 1;
            end
            b_reg <= b_reg >> 2;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_negative_count <= tally_reg;
            if (count_reg == '0) begin
                m_coeff_variation <= '0;
                m_cv_status       <= CV_ST_EMPTY;
            end else if (sum_reg == '0) begin
                m_coeff_variation <= '0;
                m_cv_status       <= CV_ST_SAT;
            end else if (sat) begin
                m_coeff_variation <= sum_reg[SUMW-1] ? CV_MIN : CV_MAX;
                m_cv_status       <= CV_ST_SAT;
            end else begin
                m_coeff_variation <= sum_reg[SUMW-1] ? -mag : mag;
                m_cv_status       <= CV_ST_OK;
            end
        end
    end

    assign stat.last_item  = (col_reg == PW'(WINDOW_SIZE - 1)) &&
                             (row_reg == PW'(WINDOW_SIZE - 1));
    assign stat.count_zero = (count_reg == '0);
    assign stat.sum_zero   = (sum_reg == '0);
    assign valid_count     = count_reg;

    `A_IMPLY(a_count_bound, 1'b1, count_reg <= NW'(ITEMS))
    `A_IMPLY(a_tally_bound, 1'b1, tally_reg <= count_reg)
    `A_NEXT(a_rem_below_divisor, cmd.div_step, rem_reg < s2_reg)

endmodule
